/* rtl/core/adts_pkg.sv */
// adts_pkg: types, constants and rate tables for the adts frame splitter
// used by every module under rtl/core; depends on nothing
`default_nettype none

package adts_pkg;

    localparam int unsigned POSITION_BITS_DEF = 32;
    localparam int unsigned WIN_BYTES         = 7;

    localparam logic [3:0] HDR_MIN    = 4'd7;
    localparam logic [3:0] HDR_PROT   = 4'd9;
    localparam logic [3:0] RATE_COUNT = 4'd13;
    localparam logic [2:0] CH_DEFAULT = 3'd2;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_MASK = 8'hF0;

    // decoded header window
    typedef struct packed {
        logic        ok;
        logic [12:0] flen;
        logic [3:0]  hlen;
        logic [3:0]  idx;
        logic [2:0]  ch;
    } hdr_info_t;

    // frame held while the rest of its bytes are counted off
    typedef struct packed {
        logic [2:0]  ch;
        logic [3:0]  idx;
        logic [3:0]  hlen;
        logic [12:0] flen;
        logic [31:0] offset;
    } frame_desc_t;

    // one result item, offset in the lowest bits
    typedef struct packed {
        logic [2:0]  channel_count;
        logic [16:0] sample_rate_hz;
        logic [63:0] timestamp_us;
        logic [3:0]  header_bytes;
        logic [12:0] frame_bytes;
        logic [31:0] frame_offset;
    } result_t;

    localparam int unsigned RESULT_BITS = $bits(result_t);
    localparam int unsigned TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    function automatic logic [16:0] rate_hz(input logic [3:0] idx);
        logic [16:0] r;
        case (idx)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            default: r = 17'd7350;
        endcase
        return r;
    endfunction

    // floor(1024 * 1e6 / rate) microseconds per frame
    function automatic logic [17:0] frame_time_us(input logic [3:0] idx);
        logic [17:0] t;
        case (idx)
            4'd0:    t = 18'd10666;
            4'd1:    t = 18'd11609;
            4'd2:    t = 18'd16000;
            4'd3:    t = 18'd21333;
            4'd4:    t = 18'd23219;
            4'd5:    t = 18'd32000;
            4'd6:    t = 18'd42666;
            4'd7:    t = 18'd46439;
            4'd8:    t = 18'd64000;
            4'd9:    t = 18'd85333;
            4'd10:   t = 18'd92879;
            4'd11:   t = 18'd128000;
            default: t = 18'd139319;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/adts_hdr_check.sv */
// adts_hdr_check: decodes a full 7-byte adts header window and checks it
// depends on adts_pkg
`default_nettype none

module adts_hdr_check (
    input  wire logic [7:0]         win [0:6],
    output adts_pkg::hdr_info_t     info
);

    logic sync;

    always_comb
    begin
        sync = (win[0] == adts_pkg::SYNC_BYTE) &&
               ((win[1] & adts_pkg::SYNC_MASK) == adts_pkg::SYNC_MASK);
        // no-crc flag set means no crc words
        info.hlen = win[1][0] ? adts_pkg::HDR_MIN : adts_pkg::HDR_PROT;
        info.idx  = win[2][5:2];
        info.ch   = {win[2][0], win[3][7:6]};
        info.flen = {win[3][1:0], win[4], win[5][7:5]};
        info.ok   = sync && (info.idx < adts_pkg::RATE_COUNT) &&
                    (info.flen >= {9'd0, info.hlen});
    end

endmodule

`default_nettype wire

/* rtl/core/adts_frame_ctrl.sv */
// adts_frame_ctrl: header window, frame byte counter, stream position and
// timestamp; builds one result item per complete frame
// depends on adts_pkg and adts_hdr_check
`default_nettype none

module adts_frame_ctrl #(
    parameter int unsigned POSITION_BITS = adts_pkg::POSITION_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_stream,
    output logic               emit_valid,
    output adts_pkg::result_t  emit_data
);

    logic [7:0]                win_reg  [0:6];
    logic [7:0]                win_next [0:6];
    logic [7:0]                chk_win  [0:6];
    logic [2:0]                fill_reg, fill_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next, off_p;
    logic                      in_frame_reg, in_frame_next;
    logic [12:0]               left_reg, left_next, left_dec;
    adts_pkg::frame_desc_t     held_reg, held_next, desc_sel, new_desc;
    logic [63:0]               ts_reg, ts_next;
    adts_pkg::hdr_info_t       hdr;

    // window as it stands once the current item is written in
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            chk_win[i] = win_reg[i];
        end
        chk_win[6] = data_byte;
    end

    adts_hdr_check u_hdr_check (
        .win  (chk_win),
        .info (hdr)
    );

    assign off_p = pos_reg - POSITION_BITS'(adts_pkg::WIN_BYTES - 1);

    always_comb
    begin
        new_desc.offset = 32'(off_p);
        new_desc.flen   = hdr.flen;
        new_desc.hlen   = hdr.hlen;
        new_desc.idx    = hdr.idx;
        new_desc.ch     = hdr.ch;
    end

    always_comb
    begin
        win_next      = win_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        left_next     = left_reg;
        held_next     = held_reg;
        ts_next       = ts_reg;
        desc_sel      = held_reg;
        emit_valid    = 1'b0;
        left_dec      = (left_reg != 13'd0) ? left_reg - 13'd1 : 13'd0;

        if (accept)
        begin
            if (in_frame_reg)
            begin
                left_next = left_dec;
                if (left_dec == 13'd0)
                begin
                    emit_valid    = 1'b1;
                    in_frame_next = 1'b0;
                    fill_next     = 3'd0;
                end
            end
            else
            begin
                win_next[fill_reg] = data_byte;
                fill_next          = fill_reg + 3'd1;
                if (fill_reg == 3'(adts_pkg::WIN_BYTES - 1))
                begin
                    if (hdr.ok)
                    begin
                        held_next = new_desc;
                        desc_sel  = new_desc;
                        if (hdr.flen == {9'd0, adts_pkg::HDR_MIN})
                        begin
                            emit_valid = 1'b1;
                            fill_next  = 3'd0;
                        end
                        else
                        begin
                            in_frame_next = 1'b1;
                            left_next     = hdr.flen - {9'd0, adts_pkg::HDR_MIN};
                        end
                    end
                    else
                    begin
                        // bad header: drop the oldest byte and keep looking
                        for (int i = 0; i < 6; i++)
                        begin
                            win_next[i] = chk_win[i + 1];
                        end
                        win_next[6] = 8'd0;
                        fill_next   = 3'(adts_pkg::WIN_BYTES - 1);
                    end
                end
            end

            pos_next = pos_reg + POSITION_BITS'(1);

            if (emit_valid)
            begin
                ts_next = ts_reg + 64'(adts_pkg::frame_time_us(desc_sel.idx));
            end

            // a truncated frame is simply abandoned here
            if (end_of_stream)
            begin
                for (int i = 0; i < 7; i++)
                begin
                    win_next[i] = 8'd0;
                end
                fill_next     = 3'd0;
                pos_next      = '0;
                in_frame_next = 1'b0;
                left_next     = 13'd0;
                held_next     = '0;
                ts_next       = 64'd0;
            end
        end
    end

    always_comb
    begin
        emit_data.frame_offset   = desc_sel.offset;
        emit_data.frame_bytes    = desc_sel.flen;
        emit_data.header_bytes   = desc_sel.hlen;
        emit_data.timestamp_us   = ts_reg;
        emit_data.sample_rate_hz = adts_pkg::rate_hz(desc_sel.idx);
        emit_data.channel_count  = (desc_sel.ch == 3'd0) ? adts_pkg::CH_DEFAULT : desc_sel.ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            fill_reg     <= 3'd0;
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
            left_reg     <= 13'd0;
            held_reg     <= '0;
            ts_reg       <= 64'd0;
        end
        else
        begin
            win_reg      <= win_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
            left_reg     <= left_next;
            held_reg     <= held_next;
            ts_reg       <= ts_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/adts_out_stage.sv */
// adts_out_stage: result register on the master side of the splitter
// depends on adts_pkg
`default_nettype none

module adts_out_stage #(
    parameter int unsigned DATA_W = adts_pkg::TDATA_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire adts_pkg::result_t load_data,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata
);

    logic              valid_reg, valid_next;
    adts_pkg::result_t data_reg;

    // a waiting item that is taken this cycle frees the register
    assign can_load   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = DATA_W'(data_reg);

endmodule

`default_nettype wire

/* rtl/core/adts_frame_splitter_top.sv */
// adts_frame_splitter_top: adts byte stream in, one item per complete frame out
// depends on adts_pkg, adts_frame_ctrl, adts_out_stage
// the item for a frame appears on m_tvalid in the cycle after its last byte is taken
// throughput: one byte per cycle while s_tready is high; header check, rate table and timestamp add are combinational
// s_tready drops only while a finished item waits and m_tready is low
// reset (rst_n low, asynchronous) clears window, counters and timestamp;
// a byte with s_tlast set returns the same state after it is processed
`default_nettype none

module adts_frame_splitter_top #(
    parameter int unsigned POSITION_BITS = adts_pkg::POSITION_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // data_byte
    input  wire logic                            s_tlast,  // end_of_stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // frame_offset[31:0], frame_bytes[44:32], header_bytes[48:45],
    // timestamp_us[112:49], sample_rate_hz[129:113], channel_count[132:130], zero fill
    output logic [adts_pkg::TDATA_BITS-1:0]      m_tdata
);

    logic              accept;
    logic              emit_valid;
    adts_pkg::result_t emit_data;

    assign accept = s_tvalid && s_tready;

    adts_frame_ctrl #(
        .POSITION_BITS (POSITION_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_tdata),
        .end_of_stream (s_tlast),
        .emit_valid    (emit_valid),
        .emit_data     (emit_data)
    );

    adts_out_stage #(
        .DATA_W (adts_pkg::TDATA_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_valid),
        .load_data (emit_data),
        .can_load  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_header_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[48:45] == adts_pkg::HDR_MIN ||
                      m_tdata[48:45] == adts_pkg::HDR_PROT))
        else $error("bad header length in result");

    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[44:32] >= {9'd0, m_tdata[48:45]}))
        else $error("frame shorter than its header");

    a_channels: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[132:130] != 3'd0))
        else $error("zero channel count in result");

endmodule

`default_nettype wire
